// ----- rtl/u8cd_pkg.sv -----
`timescale 1ns / 1ps

package u8cd_pkg;

    // lead and continuation byte patterns
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] CONT_MASK   = 8'hc0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'he0;
    localparam logic [7:0] LEAD2_TAG   = 8'hc0;
    localparam logic [7:0] LEAD3_MASK  = 8'hf0;
    localparam logic [7:0] LEAD3_TAG   = 8'he0;
    localparam logic [7:0] LEAD4_MASK  = 8'hf8;
    localparam logic [7:0] LEAD4_TAG   = 8'hf0;

    // payload masks
    localparam logic [7:0] CONT_BITS   = 8'h3f;
    localparam logic [7:0] LEAD2_BITS  = 8'h1f;
    localparam logic [7:0] LEAD3_BITS  = 8'h0f;
    localparam logic [7:0] LEAD4_BITS  = 8'h07;

    // byte counts
    localparam logic [2:0] CNT_NONE = 3'd0;
    localparam logic [2:0] CNT_ONE  = 3'd1;
    localparam logic [2:0] CNT_TWO  = 3'd2;
    localparam logic [2:0] CNT_THREE = 3'd3;
    localparam logic [2:0] CNT_FOUR = 3'd4;

    localparam int CP_W = 21;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] fourth_byte;
        logic [2:0] bytes_available;
    } t_in_item;

endpackage

// ----- rtl/u8cd_if.sv -----
`timescale 1ns / 1ps

// input request channel: byte window and count
interface u8cd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [7:0] fourth_byte;
    logic [2:0] bytes_available;

    modport source (output valid, first_byte, second_byte, third_byte, fourth_byte,
                    bytes_available, input ready);
    modport sink   (input valid, first_byte, second_byte, third_byte, fourth_byte,
                    bytes_available, output ready);
endinterface

// result request channel: decoded code point
interface u8cd_out_if;
    logic        valid;
    logic        ready;
    logic        is_empty;
    logic [20:0] code_point;
    logic [2:0]  bytes_consumed;

    modport source (output valid, is_empty, code_point, bytes_consumed, input ready);
    modport sink   (input valid, is_empty, code_point, bytes_consumed, output ready);
endinterface

// ----- rtl/u8cd_in_stage.sv -----
`timescale 1ns / 1ps

module u8cd_in_stage
    import u8cd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    u8cd_in_if.sink  i_in,
    output logic     o_valid,
    input  logic     i_ready,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;
    logic     take;

    // accept when empty or when the held request moves on
    assign i_in.ready = !r_valid || i_ready;
    assign take       = i_in.valid && i_in.ready;
    assign n_valid    = i_in.ready ? i_in.valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // capture payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= '{first_byte:      i_in.first_byte,
                        second_byte:     i_in.second_byte,
                        third_byte:      i_in.third_byte,
                        fourth_byte:     i_in.fourth_byte,
                        bytes_available: i_in.bytes_available};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/u8cd_dec_stage.sv -----
`timescale 1ns / 1ps

module u8cd_dec_stage
    import u8cd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    u8cd_out_if.source o_out
);

    logic            r_valid;
    logic            r_empty;
    logic [CP_W-1:0] r_cp;
    logic [2:0]      r_used;
    logic            n_valid;
    logic            n_empty;
    logic [CP_W-1:0] n_cp;
    logic [2:0]      n_used;
    logic            take;
    logic [2:0]      avail;
    logic [7:0]      c;
    logic [7:0]      b1;
    logic [7:0]      b2;
    logic [7:0]      b3;
    logic            cont1;
    logic            cont2;
    logic            cont3;

    assign o_ready = !r_valid || o_out.ready;
    assign take    = i_valid && o_ready;
    assign n_valid = o_ready ? i_valid : r_valid;

    assign c  = i_item.first_byte;
    assign b1 = i_item.second_byte;
    assign b2 = i_item.third_byte;
    assign b3 = i_item.fourth_byte;

    // counts above four act as four
    assign avail = i_item.bytes_available[2] ? CNT_FOUR : i_item.bytes_available;

    assign cont1 = (b1 & CONT_MASK) == CONT_TAG;
    assign cont2 = (b2 & CONT_MASK) == CONT_TAG;
    assign cont3 = (b3 & CONT_MASK) == CONT_TAG;

    // decode, falling back to the raw lead byte; no bytes available gives an empty result
    always_comb begin
        n_empty = 1'b0;
        n_cp    = {{(CP_W-8){1'b0}}, c};
        n_used  = CNT_ONE;
        if (avail == CNT_NONE) begin
            n_empty = 1'b1;
            n_cp    = '0;
            n_used  = CNT_NONE;
        end else if (c < ASCII_LIMIT) begin
            n_used  = CNT_ONE;
        end else if ((c & LEAD2_MASK) == LEAD2_TAG && avail >= CNT_TWO) begin
            if (cont1) begin
                n_cp   = {10'd0, c[4:0] & LEAD2_BITS[4:0], b1[5:0] & CONT_BITS[5:0]};
                n_used = CNT_TWO;
            end
        end else if ((c & LEAD3_MASK) == LEAD3_TAG && avail >= CNT_THREE) begin
            if (cont1 && cont2) begin
                n_cp   = {5'd0, c[3:0] & LEAD3_BITS[3:0], b1[5:0] & CONT_BITS[5:0],
                          b2[5:0] & CONT_BITS[5:0]};
                n_used = CNT_THREE;
            end
        end else if ((c & LEAD4_MASK) == LEAD4_TAG && avail >= CNT_FOUR) begin
            if (cont1 && cont2 && cont3) begin
                n_cp   = {c[2:0] & LEAD4_BITS[2:0], b1[5:0] & CONT_BITS[5:0],
                          b2[5:0] & CONT_BITS[5:0], b3[5:0] & CONT_BITS[5:0]};
                n_used = CNT_FOUR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_empty <= n_empty;
            r_cp    <= n_cp;
            r_used  <= n_used;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.is_empty       = r_empty;
    assign o_out.code_point     = r_cp;
    assign o_out.bytes_consumed = r_used;

    // empty result carries nothing and consumes nothing
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_empty |-> r_cp == '0 && r_used == CNT_NONE)
        else $error("empty result not cleared");

    // nothing consumed only when empty
    a_zero_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_used == CNT_NONE |-> r_empty)
        else $error("zero bytes consumed on a non-empty result");

    // one and two byte results fit eleven bits
    a_cp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_used <= CNT_TWO |-> r_cp[20:11] == '0)
        else $error("code point too wide for its length");

    // three-byte results fit sixteen bits
    a_cp3_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_used == CNT_THREE |-> r_cp[20:16] == '0)
        else $error("three-byte code point too wide");

    // a taken request shows up as a result in the next cycle
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_valid)
        else $error("accepted request lost");

endmodule

// ----- rtl/utf8_codepoint_decoder.sv -----
`timescale 1ns / 1ps

// channel  dir  fields
// i_in     in   first_byte, second_byte, third_byte, fourth_byte, bytes_available
// o_out    out  is_empty, code_point, bytes_consumed
//
// one request per cycle sustained while o_out.ready stays high; a request passes the input register
// and then the result register, with the decode logic between those two registers
// reset clears both stage valid flags, payload registers are not reset
// a stalled output holds its result while the input register still takes one more request

module utf8_codepoint_decoder
    import u8cd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    u8cd_in_if.sink    i_in,
    u8cd_out_if.source o_out
);

    logic     s_valid;
    logic     s_ready;
    t_in_item s_item;

    u8cd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (s_valid),
        .i_ready (s_ready),
        .o_item  (s_item)
    );

    u8cd_dec_stage u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .o_ready (s_ready),
        .i_item  (s_item),
        .o_out   (o_out)
    );

endmodule
